/* design/rbfs_pkg.sv */
// Shared constants, codes and types of the ring-buffered frame scanner.
`default_nettype none

package rbfs_pkg;

   // Ring store geometry; the depth is a power of two so pointers wrap naturally.
   localparam int RING_DEPTH  = 512;
   localparam int PTR_W       = $clog2(RING_DEPTH);
   localparam int MAX_PAYLOAD = 64;

   // Field widths of the channel words.
   localparam int DATA_W   = 8;
   localparam int STATUS_W = 3;
   localparam int FLEN_W   = 7;
   localparam int SUM_W    = 16;

   // Length byte, payload and two checksum bytes: counters cover MAX_PAYLOAD + 3.
   localparam int CNT_W          = $clog2(MAX_PAYLOAD + 3);
   localparam int FRAME_OVERHEAD = 3;
   localparam int CHECK_BYTES    = 2;

   // Frame header mark.
   localparam logic [DATA_W-1:0] HEADER_MARK = 8'hFE;

   // Input queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Item kinds.
   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_SCAN = 1'b1;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_EMPTY = 3'd0,
      ST_SKIP  = 3'd1,
      ST_WAIT  = 3'd2,
      ST_CKERR = 3'd3,
      ST_OK    = 3'd4
   } status_type;

   // One queued input word.
   typedef struct packed {
      logic              kind;
      logic [DATA_W-1:0] data_byte;
   } item_type;

   // Head of the queue as seen by the back part.
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   // Control from the back part to the front part.
   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctrl_type;

endpackage

`default_nettype wire

/* design/rbfs_ifs.sv */
// Valid/ready channel interfaces for scan requests and scan results.
`default_nettype none

interface rbfs_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [rbfs_pkg::DATA_W-1:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface rbfs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rbfs_pkg::STATUS_W-1:0] status;
   logic [rbfs_pkg::DATA_W-1:0]   payload_byte;
   logic [rbfs_pkg::FLEN_W-1:0]   frame_length;
   logic                          last;

   modport source (output valid, output status, output payload_byte,
                   output frame_length, output last, input ready);
   modport sink   (input valid, input status, input payload_byte,
                   input frame_length, input last, output ready);
endinterface

`default_nettype wire

/* design/rbfs_front.sv */
// Front part: accepts request words into a short queue for the scan engine.
`default_nettype none

module rbfs_front (
   input  wire                      clock,
   input  wire                      reset,
   rbfs_req_if.sink                 req_bus,
   input  rbfs_pkg::back_ctrl_type  back_ctrl,
   output rbfs_pkg::queue_head_type queue_head
);

   rbfs_pkg::item_type                entry_ff [rbfs_pkg::QUEUE_DEPTH];
   logic [rbfs_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [rbfs_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [rbfs_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              full;
   logic                              push;

   // No word is taken while the ring store is being cleared.
   assign full          = (count_ff == rbfs_pkg::QCNT_W'(rbfs_pkg::QUEUE_DEPTH));
   assign req_bus.ready = !full && !back_ctrl.clearing;
   assign push          = req_bus.valid && req_bus.ready;

   assign queue_head = {(count_ff != '0), entry_ff[rd_ptr_ff]};

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (back_ctrl.pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !back_ctrl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && back_ctrl.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff].kind      <= req_bus.kind;
         entry_ff[wr_ptr_ff].data_byte <= req_bus.data_byte;
      end
   end

endmodule

`default_nettype wire

/* design/rbfs_back.sv */
// Back part: ring store, scan sequencer and the result output register.
`default_nettype none

module rbfs_back (
   input  wire                      clock,
   input  wire                      reset,
   input  rbfs_pkg::queue_head_type queue_head,
   output rbfs_pkg::back_ctrl_type  back_ctrl,
   rbfs_rsp_if.source               rsp_bus
);

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_HEAD  = 9'b000000100,
      S_LEN   = 9'b000001000,
      S_CHECK = 9'b000010000,
      S_SUM   = 9'b000100000,
      S_CMP   = 9'b001000000,
      S_EMRD  = 9'b010000000,
      S_EMWR  = 9'b100000000
   } state_type;

   localparam int PW = rbfs_pkg::PTR_W;
   localparam int CW = rbfs_pkg::CNT_W;
   localparam int DW = rbfs_pkg::DATA_W;
   localparam int SW = rbfs_pkg::SUM_W;
   localparam int FW = rbfs_pkg::FLEN_W;

   // Ring store.
   logic [DW-1:0] ring_mem [rbfs_pkg::RING_DEPTH];
   logic          mem_we;
   logic [PW-1:0] mem_waddr;
   logic [DW-1:0] mem_wdata;
   logic          mem_re;
   logic [PW-1:0] mem_raddr;
   logic [DW-1:0] rdata_ff;

   // Sequencer state.
   state_type     state_ff, state_in;
   logic [PW-1:0] clr_ff, clr_in;
   logic [PW-1:0] wp_ff, wp_in;
   logic [PW-1:0] rp_ff, rp_in;
   logic [PW-1:0] addr_ff, addr_in;
   logic [DW-1:0] head_ff, head_in;
   logic [FW-1:0] len_ff, len_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [DW-1:0] word_lo_ff, word_lo_in;
   logic [DW-1:0] word_hi_ff, word_hi_in;
   logic [CW-1:0] iss_ff, iss_in;
   logic [CW-1:0] rcv_ff, rcv_in;
   logic          rvalid_ff, rvalid_in;

   // Output register.
   logic                   out_valid_ff, out_valid_in;
   rbfs_pkg::status_type   out_status_ff, out_status_in;
   logic [DW-1:0]          out_pay_ff, out_pay_in;
   logic [FW-1:0]          out_flen_ff, out_flen_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_free;
   logic                   out_load;

   // Scan decisions.
   logic [PW-1:0] avail;
   logic [PW:0]   needed;
   logic          bad_header;
   logic          too_few;
   logic [CW-1:0] read_total;
   logic          emit_last;

   assign out_free = !out_valid_ff || rsp_bus.ready;

   assign avail      = wp_ff - rp_ff;
   assign needed     = (PW+1)'(rdata_ff) + (PW+1)'(rbfs_pkg::FRAME_OVERHEAD);
   assign bad_header = (head_ff != rbfs_pkg::HEADER_MARK) || (rdata_ff == '0) ||
                       (rdata_ff > DW'(rbfs_pkg::MAX_PAYLOAD));
   assign too_few    = ((PW+1)'(avail) < needed);
   assign read_total = CW'(len_ff) + CW'(rbfs_pkg::CHECK_BYTES);
   assign emit_last  = (iss_ff == CW'(len_ff) - 1'b1);

   // Sequencer next state and datapath.
   always_comb begin
      state_in           = state_ff;
      clr_in             = clr_ff;
      wp_in              = wp_ff;
      rp_in              = rp_ff;
      addr_in            = addr_ff;
      head_in            = head_ff;
      len_in             = len_ff;
      sum_in             = sum_ff;
      word_lo_in         = word_lo_ff;
      word_hi_in         = word_hi_ff;
      iss_in             = iss_ff;
      rcv_in             = rcv_ff;
      rvalid_in          = 1'b0;
      mem_we             = 1'b0;
      mem_waddr          = wp_ff;
      mem_wdata          = queue_head.item.data_byte;
      mem_re             = 1'b0;
      mem_raddr          = addr_ff;
      back_ctrl.pop      = 1'b0;
      back_ctrl.clearing = (state_ff == S_CLEAR);
      out_load           = 1'b0;
      out_status_in      = rbfs_pkg::ST_EMPTY;
      out_pay_in         = '0;
      out_flen_in        = '0;
      out_last_in        = 1'b1;

      unique case (state_ff)
         // Zero the whole ring store, one entry a cycle.
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == PW'(rbfs_pkg::RING_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         // Take the next word: a push is done here, a scan starts.
         S_IDLE: begin
            if (queue_head.valid) begin
               back_ctrl.pop = 1'b1;
               if (queue_head.item.kind == rbfs_pkg::KIND_PUSH) begin
                  mem_we = 1'b1;
                  wp_in  = wp_ff + 1'b1;
               end else begin
                  state_in = S_HEAD;
               end
            end
         end
         // An empty ring reports once the output register is free; otherwise fetch the header byte.
         S_HEAD: begin
            if (rp_ff == wp_ff) begin
               if (out_free) begin
                  out_load      = 1'b1;
                  out_status_in = rbfs_pkg::ST_EMPTY;
                  state_in      = S_IDLE;
               end
            end else begin
               mem_re    = 1'b1;
               mem_raddr = rp_ff - 1'b1;
               state_in  = S_LEN;
            end
         end
         // Keep the header byte and fetch the length byte.
         S_LEN: begin
            head_in   = rdata_ff;
            mem_re    = 1'b1;
            mem_raddr = rp_ff;
            state_in  = S_CHECK;
         end
         // Judge header, length and fill level.
         S_CHECK: begin
            if (bad_header) begin
               if (out_free) begin
                  out_load      = 1'b1;
                  out_status_in = rbfs_pkg::ST_SKIP;
                  rp_in         = rp_ff + 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (too_few) begin
               if (out_free) begin
                  out_load      = 1'b1;
                  out_status_in = rbfs_pkg::ST_WAIT;
                  state_in      = S_IDLE;
               end
            end else begin
               len_in   = FW'(rdata_ff);
               sum_in   = SW'(rdata_ff);
               addr_in  = rp_ff + 1'b1;
               iss_in   = '0;
               rcv_in   = '0;
               state_in = S_SUM;
            end
         end
         // Stream payload and checksum bytes, one read issued per cycle.
         S_SUM: begin
            if (iss_ff != read_total) begin
               mem_re    = 1'b1;
               addr_in   = addr_ff + 1'b1;
               iss_in    = iss_ff + 1'b1;
               rvalid_in = 1'b1;
            end
            if (rvalid_ff) begin
               rcv_in = rcv_ff + 1'b1;
               if (rcv_ff < CW'(len_ff)) begin
                  sum_in = sum_ff + SW'(rdata_ff);
               end else if (rcv_ff == CW'(len_ff)) begin
                  word_lo_in = rdata_ff;
               end else begin
                  word_hi_in = rdata_ff;
                  state_in   = S_CMP;
               end
            end
         end
         // Compare the sum with the stored little-endian word.
         S_CMP: begin
            if (sum_ff != {word_hi_ff, word_lo_ff}) begin
               if (out_free) begin
                  out_load      = 1'b1;
                  out_status_in = rbfs_pkg::ST_CKERR;
                  rp_in         = rp_ff + 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               addr_in  = rp_ff + 1'b1;
               iss_in   = '0;
               state_in = S_EMRD;
            end
         end
         // Fetch the next payload byte.
         S_EMRD: begin
            mem_re   = 1'b1;
            addr_in  = addr_ff + 1'b1;
            state_in = S_EMWR;
         end
         // Hand the payload byte to the output register.
         S_EMWR: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_status_in = rbfs_pkg::ST_OK;
               out_pay_in    = rdata_ff;
               out_flen_in   = len_ff;
               out_last_in   = emit_last;
               iss_in        = iss_ff + 1'b1;
               if (emit_last) begin
                  rp_in    = rp_ff + PW'(len_ff) + PW'(rbfs_pkg::FRAME_OVERHEAD);
                  state_in = S_IDLE;
               end else begin
                  state_in = S_EMRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: loads a new word or drops the one taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         wp_ff        <= '0;
         rp_ff        <= '0;
         rvalid_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         rvalid_ff    <= rvalid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      head_ff    <= head_in;
      len_ff     <= len_in;
      sum_ff     <= sum_in;
      word_lo_ff <= word_lo_in;
      word_hi_ff <= word_hi_in;
      iss_ff     <= iss_in;
      rcv_ff     <= rcv_in;
      if (out_load) begin
         out_status_ff <= out_status_in;
         out_pay_ff    <= out_pay_in;
         out_flen_ff   <= out_flen_in;
         out_last_ff   <= out_last_in;
      end
   end

   // Ring store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= ring_mem[mem_raddr];
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.status       = out_status_ff;
   assign rsp_bus.payload_byte = out_pay_ff;
   assign rsp_bus.frame_length = out_flen_ff;
   assign rsp_bus.last         = out_last_ff;

endmodule

`default_nettype wire

/* design/ring_buffered_frame_scanner.sv */
// Top level of the ring-buffered frame scanner.
//
// The req_bus channel carries words of two kinds: a push stores data_byte in
// a 512-byte ring store, a scan makes one step of frame search at the read
// pointer. A push gives no result; a scan gives one result word (ring empty,
// byte skipped, waiting for bytes, checksum error) or, for a good frame, one
// word per payload byte on rsp_bus, with last set on the final word.
// Words pass through a four-entry queue to the scan engine, so the sender
// may run ahead of the engine.
// In the engine, a push is written to the ring store from the idle state. A
// scan first checks for an empty ring, then reads the header and length
// bytes through the registered read port and judges them with the fill
// level; a frame that passes has its length and payload bytes summed and
// compared with the two checksum bytes, and a good frame then has each
// payload byte read and handed out in turn. Words are taken only in idle.
// After reset the ring store is zeroed one entry per cycle, and
// req_bus.ready stays low until that is done. When the receiver stalls, the
// result is held in the output register and the engine waits behind it;
// the queue keeps taking words until it is full.
`default_nettype none

module ring_buffered_frame_scanner (
   input  wire         clock,
   input  wire         reset,
   rbfs_req_if.sink    req_bus,
   rbfs_rsp_if.source  rsp_bus
);

   rbfs_pkg::queue_head_type queue_head;
   rbfs_pkg::back_ctrl_type  back_ctrl;

   rbfs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .back_ctrl  (back_ctrl),
      .queue_head (queue_head)
   );

   rbfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .queue_head (queue_head),
      .back_ctrl  (back_ctrl),
      .rsp_bus    (rsp_bus)
   );

   // The engine only takes a word that the queue holds.
   assert property (@(posedge clock) disable iff (reset)
      back_ctrl.pop |-> queue_head.valid)
      else $error("queue popped while empty");

   // No request word is taken while the ring store is being cleared.
   assert property (@(posedge clock) disable iff (reset)
      back_ctrl.clearing |-> !req_bus.ready)
      else $error("request taken during ring clear");

   // A frame word always carries a legal payload length.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status == rbfs_pkg::ST_OK) |->
         (rsp_bus.frame_length != '0 &&
          rsp_bus.frame_length <= rbfs_pkg::FLEN_W'(rbfs_pkg::MAX_PAYLOAD)))
      else $error("frame word with illegal length");

   // Every other result is a lone, final word with cleared fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status != rbfs_pkg::ST_OK) |->
         (rsp_bus.last && rsp_bus.payload_byte == '0 && rsp_bus.frame_length == '0))
      else $error("status word with stray fields");

endmodule

`default_nettype wire
